// ===== design/qjt_pkg.sv =====
// quintic joint trajectory package: codes, field widths, storage record types
// used by qjt_eval and the top level; no dependencies
`timescale 1ns / 1ps

package qjt_pkg;

    // design defaults
    localparam int NUM_JOINTS_DEF = 8;
    localparam int EVAL_MAX       = 8;

    // input command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_PLAN = 2'd1;
    localparam logic [1:0] CMD_EVAL = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_MODE    = 2'd1;
    localparam logic [1:0] ST_ZERO_LIMIT = 2'd2;
    localparam logic [1:0] ST_SAT        = 2'd3;

    // configuration register indexes
    localparam logic REG_USE_VEL = 1'b0;
    localparam logic REG_USE_ACC = 1'b1;

    // fixed-point constants
    localparam logic [16:0]        SQRT3_Q16 = 17'd113512;
    localparam logic signed [63:0] Q_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0]        TF_MAX    = 32'hFFFF_FFFF;

    // divider fraction shifts
    localparam logic [5:0] SH_16 = 6'd16;
    localparam logic [5:0] SH_32 = 6'd32;
    localparam logic [5:0] SH_48 = 6'd48;

    // per-joint limit record
    typedef struct packed {
        logic [30:0] acc_max;
        logic [30:0] vel_max;
    } limits_t;

    // per-joint polynomial record
    typedef struct packed {
        logic signed [31:0] c0;
        logic signed [63:0] c3;
        logic signed [63:0] c4;
        logic signed [63:0] c5;
    } coef_t;

    // evaluation results handed from the evaluator to the top level
    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic               sat;
    } eval_res_t;

endpackage

// ===== design/qjt_mem.sv =====
// synchronous per-joint state memory, one write and one read port, registered read
// entries read as zero until first written; depends on nothing
`timescale 1ns / 1ps

module qjt_mem #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;

    // valid bits cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // storage array and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/qjt_div.sv =====
// restoring divider, floor(n * 2^sh / m) one quotient bit a cycle, saturating
// depends on nothing
`timescale 1ns / 1ps

module qjt_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [5:0]  shift,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic        sat
);

    logic [111:0] sr_reg;
    logic [63:0]  r_reg;
    logic [63:0]  q_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic         sat_reg;

    logic [64:0]  r_shift;
    logic         r_ge;

    // one restoring step
    always_comb begin
        r_shift = {r_reg, sr_reg[111]};
        r_ge    = r_shift >= {1'b0, divisor};
    end

    // iteration control and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                sr_reg   <= {dividend, 48'd0};
                r_reg    <= '0;
                q_reg    <= '0;
                cnt_reg  <= 7'd64 + {1'b0, shift};
                busy_reg <= 1'b1;
                sat_reg  <= 1'b0;
            end else if (busy_reg) begin
                if (q_reg[63]) begin
                    // quotient would overflow 64 bits
                    q_reg    <= '1;
                    sat_reg  <= 1'b1;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    sr_reg  <= {sr_reg[110:0], 1'b0};
                    r_reg   <= r_ge ? 64'(r_shift - {1'b0, divisor}) : r_shift[63:0];
                    q_reg   <= {q_reg[62:0], r_ge};
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign sat      = sat_reg;

endmodule

// ===== design/qjt_sqrt.sv =====
// integer square root of a 64-bit value, two radicand bits a cycle
// depends on nothing
`timescale 1ns / 1ps

module qjt_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [63:0] trial;

    always_comb begin
        trial = res_reg + bit_reg;
    end

    // digit-by-digit root
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= radicand;
                res_reg  <= '0;
                bit_reg  <= 64'd1 << 62;
                cnt_reg  <= '1;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (x_reg >= trial) begin
                    x_reg   <= x_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ===== design/qjt_eval.sv =====
// polynomial evaluator: Horner steps for position, velocity, acceleration of one joint
// in saturating Q32.32 with one 32x32 multiplier; uses qjt_pkg
`timescale 1ns / 1ps

module qjt_eval (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  qjt_pkg::coef_t     coef,
    input  logic [31:0]        sample_time,
    output logic               done,
    output qjt_pkg::eval_res_t res
);

    typedef enum logic [1:0] {OP_LOAD, OP_ADD, OP_MUL, OP_OUT} op_t;
    typedef enum logic [1:0] {SEL_C3, SEL_C4, SEL_C5} csel_t;
    typedef enum logic [1:0] {DST_POS, DST_VEL, DST_ACC} dst_t;

    typedef struct packed {
        op_t        op;
        csel_t      sel;
        logic [4:0] k;
        dst_t       dst;
        logic       fin;
    } step_t;

    // microprogram: three Horner chains
    function automatic step_t prog(input logic [4:0] pc);
        step_t s;
        s = '{op: OP_MUL, sel: SEL_C5, k: 5'd1, dst: DST_POS, fin: 1'b0};
        unique case (pc)
            5'd0:  s = '{op: OP_LOAD, sel: SEL_C5, k: 5'd1,  dst: DST_POS, fin: 1'b0};
            5'd2:  s = '{op: OP_ADD,  sel: SEL_C4, k: 5'd1,  dst: DST_POS, fin: 1'b0};
            5'd4:  s = '{op: OP_ADD,  sel: SEL_C3, k: 5'd1,  dst: DST_POS, fin: 1'b0};
            5'd8:  s = '{op: OP_OUT,  sel: SEL_C3, k: 5'd1,  dst: DST_POS, fin: 1'b0};
            5'd9:  s = '{op: OP_LOAD, sel: SEL_C5, k: 5'd5,  dst: DST_VEL, fin: 1'b0};
            5'd11: s = '{op: OP_ADD,  sel: SEL_C4, k: 5'd4,  dst: DST_VEL, fin: 1'b0};
            5'd13: s = '{op: OP_ADD,  sel: SEL_C3, k: 5'd3,  dst: DST_VEL, fin: 1'b0};
            5'd16: s = '{op: OP_OUT,  sel: SEL_C3, k: 5'd1,  dst: DST_VEL, fin: 1'b0};
            5'd17: s = '{op: OP_LOAD, sel: SEL_C5, k: 5'd20, dst: DST_ACC, fin: 1'b0};
            5'd19: s = '{op: OP_ADD,  sel: SEL_C4, k: 5'd12, dst: DST_ACC, fin: 1'b0};
            5'd21: s = '{op: OP_ADD,  sel: SEL_C3, k: 5'd6,  dst: DST_ACC, fin: 1'b0};
            5'd23: s = '{op: OP_OUT,  sel: SEL_C3, k: 5'd1,  dst: DST_ACC, fin: 1'b1};
            default: s = '{op: OP_MUL, sel: SEL_C5, k: 5'd1, dst: DST_POS, fin: 1'b0};
        endcase
        return s;
    endfunction

    localparam logic signed [69:0] QMAX70 = 70'(qjt_pkg::Q_MAX);
    localparam logic signed [64:0] QMAX65 = 65'(qjt_pkg::Q_MAX);
    localparam logic [63:0]        HI_LIM = 64'(qjt_pkg::Q_MAX) >> 16;

    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         pc_reg;
    logic [1:0]         ph_reg;
    qjt_pkg::coef_t     coef_reg;
    logic [31:0]        t_reg;
    logic signed [63:0] h_reg;
    logic signed [63:0] scl_reg;
    logic               neg_reg;
    logic [62:0]        mag_reg;
    logic [63:0]        plo_reg;
    logic [63:0]        phi_reg;
    qjt_pkg::eval_res_t res_reg;

    step_t              stp;
    logic signed [63:0] operand;
    logic signed [69:0] prod;
    logic signed [63:0] scl_val;
    logic               scl_sat;
    logic signed [64:0] sum;
    logic signed [63:0] sum_val;
    logic               sum_sat;
    logic [63:0]        habs;
    logic [63:0]        rmag;
    logic               mul_big;
    logic               mul_sat;
    logic signed [63:0] mul_val;
    logic signed [63:0] qtr;
    logic signed [63:0] vsum;
    logic signed [31:0] out_val;
    logic               out_sat;

    // step datapath
    always_comb begin
        stp = prog(pc_reg);
        unique case (stp.sel)
            SEL_C3:  operand = coef_reg.c3;
            SEL_C4:  operand = coef_reg.c4;
            SEL_C5:  operand = coef_reg.c5;
            default: operand = coef_reg.c5;
        endcase
        // small-integer scaling with clamp
        prod    = 70'(operand) * 70'($signed({1'b0, stp.k}));
        scl_sat = (prod > QMAX70) || (prod < -QMAX70);
        if (prod > QMAX70) begin
            scl_val = qjt_pkg::Q_MAX;
        end else if (prod < -QMAX70) begin
            scl_val = -qjt_pkg::Q_MAX;
        end else begin
            scl_val = prod[63:0];
        end
        // saturating sum
        sum     = 65'(h_reg) + 65'(scl_reg);
        sum_sat = (sum > QMAX65) || (sum < -QMAX65);
        if (sum > QMAX65) begin
            sum_val = qjt_pkg::Q_MAX;
        end else if (sum < -QMAX65) begin
            sum_val = -qjt_pkg::Q_MAX;
        end else begin
            sum_val = sum[63:0];
        end
        // multiply by time, recombine partial products
        habs    = h_reg[63] ? 64'(-h_reg) : 64'(h_reg);
        mul_big = phi_reg > HI_LIM;
        rmag    = (phi_reg << 16) + (plo_reg >> 16);
        mul_sat = mul_big || (rmag > 64'(qjt_pkg::Q_MAX));
        if (mul_sat) begin
            mul_val = neg_reg ? -qjt_pkg::Q_MAX : qjt_pkg::Q_MAX;
        end else begin
            mul_val = neg_reg ? -$signed(rmag) : $signed(rmag);
        end
        // truncate toward zero to Q16.16, add start to the position only, clamp to 32 bits
        qtr = (h_reg >>> 16) + 64'((h_reg[63] && (h_reg[15:0] != 16'd0)) ? 1 : 0);
        vsum = qtr + ((stp.dst == DST_POS) ? 64'(coef_reg.c0) : 64'sd0);
        out_sat = (vsum > 64'sd2147483647) || (vsum < -64'sd2147483648);
        if (vsum > 64'sd2147483647) begin
            out_val = 32'sh7FFF_FFFF;
        end else if (vsum < -64'sd2147483648) begin
            out_val = 32'sh8000_0000;
        end else begin
            out_val = vsum[31:0];
        end
    end

    // sequencer and accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg    <= 1'b1;
                pc_reg      <= '0;
                ph_reg      <= '0;
                coef_reg    <= coef;
                t_reg       <= sample_time;
                h_reg       <= '0;
                res_reg.sat <= 1'b0;
            end else if (busy_reg) begin
                unique case (stp.op)
                    OP_LOAD, OP_ADD: begin
                        if (ph_reg == 2'd0) begin
                            scl_reg <= scl_val;
                            if (scl_sat) res_reg.sat <= 1'b1;
                            ph_reg <= 2'd1;
                        end else begin
                            if (stp.op == OP_LOAD) begin
                                h_reg <= scl_reg;
                            end else begin
                                h_reg <= sum_val;
                                if (sum_sat) res_reg.sat <= 1'b1;
                            end
                            ph_reg <= 2'd0;
                            pc_reg <= pc_reg + 5'd1;
                        end
                    end
                    OP_MUL: begin
                        unique case (ph_reg)
                            2'd0: begin
                                neg_reg <= h_reg[63];
                                mag_reg <= habs[62:0];
                                plo_reg <= 64'(habs[31:0]) * 64'(t_reg);
                                ph_reg  <= 2'd1;
                            end
                            2'd1: begin
                                phi_reg <= 64'(mag_reg[62:32]) * 64'(t_reg);
                                ph_reg  <= 2'd2;
                            end
                            default: begin
                                h_reg <= mul_val;
                                if (mul_sat) res_reg.sat <= 1'b1;
                                ph_reg <= 2'd0;
                                pc_reg <= pc_reg + 5'd1;
                            end
                        endcase
                    end
                    default: begin
                        if (out_sat) res_reg.sat <= 1'b1;
                        unique case (stp.dst)
                            DST_POS: res_reg.position     <= out_val;
                            DST_VEL: res_reg.velocity     <= out_val;
                            default: res_reg.acceleration <= out_val;
                        endcase
                        pc_reg <= pc_reg + 5'd1;
                        if (stp.fin) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== design/quintic_joint_trajectory.sv =====
// top level of the quintic joint trajectory planner and evaluator
// uses qjt_pkg, qjt_mem, qjt_div, qjt_sqrt and qjt_eval
`timescale 1ns / 1ps

// Usage: the input stream carries one command per transaction (kind in s_tuser).
// A load stores one joint's velocity and acceleration limits; a plan derives that
// joint's duration, stores its quintic coefficients and updates the running move
// duration; an evaluate returns position, velocity and acceleration for every
// joint from joint 0 up, m_tlast marking the final one. Load and plan return one
// result with m_tlast set; a load or plan whose joint index is beyond the joint
// count, or command 3, is dropped without a result.
// A load passes through S_LD_WR and S_EMIT to the output register. Plan time is set
// by the shared bit-serial divider (up to 14 divisions) and the square root when a
// duration is computed. Evaluate time per joint is set by the single 32x32
// multiplier, used in turn for each of the twelve multiply-by-time steps.
// One command is processed at a time; the next is accepted once its results are
// in the output register, so a stalled receiver holds the block only when a
// further result must be written. Reset clears the limit and coefficient
// memories (valid bits), the move duration and the output valid flag; the
// configuration comes back to velocity bound enabled, acceleration bound off.
module quintic_joint_trajectory #(
    parameter int NUM_JOINTS = qjt_pkg::NUM_JOINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // joint_index, first_of_plan, start_pos, end_pos, vel_limit, acc_limit, sample_time
    input  logic [167:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_joint, position, velocity, acceleration, move_duration, status
    output logic [135:0] m_tdata,
    output logic         m_tlast,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW          = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int EVAL_JOINTS = (NUM_JOINTS < qjt_pkg::EVAL_MAX) ? NUM_JOINTS
                                                                  : qjt_pkg::EVAL_MAX;
    localparam int LIM_W       = $bits(qjt_pkg::limits_t);
    localparam int COEF_W      = $bits(qjt_pkg::coef_t);

    typedef enum logic [4:0] {
        S_IDLE, S_LD_WR, S_PL_RD, S_PL_CHK, S_PL_VWAIT, S_PL_AMUL, S_PL_ASTART,
        S_PL_AWAIT, S_PL_SQWAIT, S_PL_TF, S_PL_CSTART, S_PL_CWAIT, S_PL_WR, S_EMIT,
        S_EV_RD, S_EV_WAIT, S_EV_RUN, S_EV_EMIT
    } state_t;

    state_t             state_reg;
    logic               uv_reg;
    logic               ua_reg;
    logic [2:0]         j_reg;
    logic               first_reg;
    logic signed [31:0] start_reg;
    logic               dneg_reg;
    logic [32:0]        dm_reg;
    logic [31:0]        t_reg;
    logic [30:0]        vlim_reg;
    logic [30:0]        alim_reg;
    logic [31:0]        longest_reg;
    logic [1:0]         status_reg;
    logic               sat_reg;
    logic [31:0]        tf_reg;
    logic [47:0]        am_reg;
    logic [1:0]         ci_reg;
    logic [2:0]         steps_reg;
    logic signed [63:0] c3_reg;
    logic signed [63:0] c4_reg;
    logic signed [63:0] c5_reg;
    logic [2:0]         ev_reg;
    logic               div_start_reg;
    logic [63:0]        div_n_reg;
    logic [63:0]        div_m_reg;
    logic [5:0]         div_sh_reg;
    logic               sq_start_reg;
    logic [63:0]        sq_x_reg;

    logic               m_valid_reg;
    logic [2:0]         m_joint_reg;
    logic signed [31:0] m_pos_reg;
    logic signed [31:0] m_vel_reg;
    logic signed [31:0] m_acc_reg;
    logic [31:0]        m_dur_reg;
    logic [1:0]         m_status_reg;
    logic               m_last_reg;

    logic               s_accept;
    logic               cfg_write;
    logic               out_free;
    logic               emit;
    logic signed [32:0] d_in;
    logic               j_ok;
    qjt_pkg::limits_t   lim_rdata;
    logic [LIM_W-1:0]   lim_raw;
    qjt_pkg::limits_t   lim_wdata;
    qjt_pkg::coef_t     coef_rdata;
    logic [COEF_W-1:0]  coef_raw;
    qjt_pkg::coef_t     coef_wdata;
    logic [AW-1:0]      lim_addr;
    logic [AW-1:0]      coef_waddr;
    logic [AW-1:0]      coef_raddr;
    logic               div_done;
    logic [63:0]        div_q;
    logic               div_sat;
    logic               sq_done;
    logic [31:0]        sq_root;
    logic               ev_done;
    qjt_pkg::eval_res_t ev_res;
    logic [3:0]         kmul;
    logic [63:0]        kd;
    logic               c_ovf;
    logic [63:0]        c_mag;
    logic               c_neg;
    logic signed [63:0] c_val;

    // handshakes and decode
    always_comb begin
        s_accept  = s_tvalid && s_tready;
        cfg_write = psel && penable && pwrite && pready;
        out_free  = !m_valid_reg || m_tready;
        emit      = out_free && ((state_reg == S_EMIT) || (state_reg == S_EV_EMIT));
        d_in      = 33'($signed(s_tdata[67:36])) - 33'($signed(s_tdata[35:4]));
        j_ok      = 32'(s_tdata[2:0]) < NUM_JOINTS;
        lim_addr  = AW'(j_reg);
        coef_waddr = AW'(j_reg);
        coef_raddr = AW'(ev_reg);
        lim_rdata = lim_raw;
        coef_rdata = coef_raw;
        lim_wdata.acc_max = alim_reg;
        lim_wdata.vel_max = vlim_reg;
        coef_wdata.c0 = start_reg;
        coef_wdata.c3 = c3_reg;
        coef_wdata.c4 = c4_reg;
        coef_wdata.c5 = c5_reg;
        // k times distance for the coefficient under work
        unique case (ci_reg)
            2'd0:    kmul = 4'd10;
            2'd1:    kmul = 4'd15;
            default: kmul = 4'd6;
        endcase
        kd    = 64'(dm_reg) * 64'(kmul);
        // coefficient magnitude, clamp and sign
        c_ovf = div_sat || div_q[63];
        c_mag = c_ovf ? 64'(qjt_pkg::Q_MAX) : div_q;
        c_neg = (ci_reg == 2'd1) ? !dneg_reg : dneg_reg;
        c_val = c_neg ? -$signed(c_mag) : $signed(c_mag);
    end

    assign s_tready = (state_reg == S_IDLE);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == qjt_pkg::REG_USE_ACC) ? {31'd0, ua_reg} : {31'd0, uv_reg};

    // limit memory
    qjt_mem #(.WIDTH(LIM_W), .DEPTH(NUM_JOINTS), .AW(AW)) u_lim_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (state_reg == S_LD_WR),
        .waddr   (lim_addr),
        .wdata   (lim_wdata),
        .re      (state_reg == S_PL_RD),
        .raddr   (lim_addr),
        .rdata   (lim_raw)
    );

    // coefficient memory
    qjt_mem #(.WIDTH(COEF_W), .DEPTH(NUM_JOINTS), .AW(AW)) u_coef_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (state_reg == S_PL_WR),
        .waddr   (coef_waddr),
        .wdata   (coef_wdata),
        .re      (state_reg == S_EV_RD),
        .raddr   (coef_raddr),
        .rdata   (coef_raw)
    );

    // shared divider
    qjt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_n_reg),
        .shift    (div_sh_reg),
        .divisor  (div_m_reg),
        .done     (div_done),
        .quotient (div_q),
        .sat      (div_sat)
    );

    // square root for the acceleration bound
    qjt_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start_reg),
        .radicand (sq_x_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    // polynomial evaluator
    qjt_eval u_eval (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (state_reg == S_EV_WAIT),
        .coef        (coef_rdata),
        .sample_time (t_reg),
        .done        (ev_done),
        .res         (ev_res)
    );

    // command sequencer, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            uv_reg        <= 1'b1;
            ua_reg        <= 1'b0;
            longest_reg   <= '0;
            m_valid_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            sq_start_reg  <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            sq_start_reg  <= 1'b0;

            // output valid: set on a new result, cleared when taken
            if (emit) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;

            // configuration writes
            if (cfg_write) begin
                if (paddr[2] == qjt_pkg::REG_USE_ACC) ua_reg <= pwdata[0];
                else                                  uv_reg <= pwdata[0];
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        j_reg     <= s_tdata[2:0];
                        first_reg <= s_tdata[3];
                        start_reg <= s_tdata[35:4];
                        dneg_reg  <= d_in[32];
                        dm_reg    <= d_in[32] ? 33'(-d_in) : 33'(d_in);
                        vlim_reg  <= s_tdata[98:68];
                        alim_reg  <= s_tdata[129:99];
                        t_reg     <= s_tdata[161:130];
                        ev_reg    <= '0;
                        priority case (1'b1)
                            (s_tuser == qjt_pkg::CMD_LOAD) && j_ok: state_reg <= S_LD_WR;
                            (s_tuser == qjt_pkg::CMD_PLAN) && j_ok: state_reg <= S_PL_RD;
                            (s_tuser == qjt_pkg::CMD_EVAL):         state_reg <= S_EV_RD;
                            default:                                state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_LD_WR: begin
                    status_reg <= qjt_pkg::ST_OK;
                    state_reg  <= S_EMIT;
                end
                S_PL_RD: begin
                    state_reg <= S_PL_CHK;
                end
                S_PL_CHK: begin
                    sat_reg <= 1'b0;
                    tf_reg  <= '0;
                    ci_reg  <= '0;
                    if (!uv_reg && !ua_reg) begin
                        status_reg <= qjt_pkg::ST_NO_MODE;
                        state_reg  <= S_EMIT;
                    end else if (dm_reg == 33'd0) begin
                        c3_reg    <= '0;
                        c4_reg    <= '0;
                        c5_reg    <= '0;
                        state_reg <= S_PL_WR;
                    end else if ((uv_reg && lim_rdata.vel_max == 31'd0)
                                 || (ua_reg && lim_rdata.acc_max == 31'd0)) begin
                        status_reg <= qjt_pkg::ST_ZERO_LIMIT;
                        state_reg  <= S_EMIT;
                    end else if (uv_reg) begin
                        // velocity bound 15|d| / (8 vmax)
                        div_n_reg     <= 64'(dm_reg) * 64'd15;
                        div_sh_reg    <= qjt_pkg::SH_16;
                        div_m_reg     <= 64'({lim_rdata.vel_max, 3'b000});
                        div_start_reg <= 1'b1;
                        state_reg     <= S_PL_VWAIT;
                    end else begin
                        state_reg <= S_PL_AMUL;
                    end
                end
                S_PL_VWAIT: begin
                    if (div_done) begin
                        if (div_sat || (div_q > 64'(qjt_pkg::TF_MAX))) begin
                            sat_reg <= 1'b1;
                            tf_reg  <= qjt_pkg::TF_MAX;
                        end else begin
                            tf_reg <= div_q[31:0];
                        end
                        state_reg <= ua_reg ? S_PL_AMUL : S_PL_TF;
                    end
                end
                S_PL_AMUL: begin
                    am_reg    <= 48'(lim_rdata.acc_max) * 48'(qjt_pkg::SQRT3_Q16);
                    state_reg <= S_PL_ASTART;
                end
                S_PL_ASTART: begin
                    // acceleration bound sqrt(10|d| / (sqrt3 amax))
                    div_n_reg     <= 64'(dm_reg) * 64'd10;
                    div_sh_reg    <= qjt_pkg::SH_48;
                    div_m_reg     <= 64'(am_reg);
                    div_start_reg <= 1'b1;
                    state_reg     <= S_PL_AWAIT;
                end
                S_PL_AWAIT: begin
                    if (div_done) begin
                        if (div_sat) begin
                            sat_reg   <= 1'b1;
                            tf_reg    <= qjt_pkg::TF_MAX;
                            state_reg <= S_PL_TF;
                        end else begin
                            sq_x_reg     <= div_q;
                            sq_start_reg <= 1'b1;
                            state_reg    <= S_PL_SQWAIT;
                        end
                    end
                end
                S_PL_SQWAIT: begin
                    if (sq_done) begin
                        if (sq_root > tf_reg) tf_reg <= sq_root;
                        state_reg <= S_PL_TF;
                    end
                end
                S_PL_TF: begin
                    if (tf_reg == 32'd0) tf_reg <= 32'd1;
                    state_reg <= S_PL_CSTART;
                end
                S_PL_CSTART: begin
                    div_n_reg     <= kd;
                    div_sh_reg    <= qjt_pkg::SH_32;
                    div_m_reg     <= 64'(tf_reg);
                    div_start_reg <= 1'b1;
                    steps_reg     <= 3'(ci_reg) + 3'd2;
                    state_reg     <= S_PL_CWAIT;
                end
                S_PL_CWAIT: begin
                    if (div_done) begin
                        if (!div_sat && steps_reg != 3'd0) begin
                            // one further power of the duration
                            div_n_reg     <= div_q;
                            div_sh_reg    <= qjt_pkg::SH_16;
                            div_start_reg <= 1'b1;
                            steps_reg     <= steps_reg - 3'd1;
                        end else begin
                            if (c_ovf) sat_reg <= 1'b1;
                            unique case (ci_reg)
                                2'd0:    c3_reg <= c_val;
                                2'd1:    c4_reg <= c_val;
                                default: c5_reg <= c_val;
                            endcase
                            if (ci_reg == 2'd2) begin
                                state_reg <= S_PL_WR;
                            end else begin
                                ci_reg    <= ci_reg + 2'd1;
                                state_reg <= S_PL_CSTART;
                            end
                        end
                    end
                end
                S_PL_WR: begin
                    if (first_reg || (tf_reg > longest_reg)) longest_reg <= tf_reg;
                    status_reg <= sat_reg ? qjt_pkg::ST_SAT : qjt_pkg::ST_OK;
                    state_reg  <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_joint_reg  <= j_reg;
                        m_pos_reg    <= '0;
                        m_vel_reg    <= '0;
                        m_acc_reg    <= '0;
                        m_dur_reg    <= longest_reg;
                        m_status_reg <= status_reg;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_EV_RD: begin
                    state_reg <= S_EV_WAIT;
                end
                S_EV_WAIT: begin
                    state_reg <= S_EV_RUN;
                end
                S_EV_RUN: begin
                    if (ev_done) state_reg <= S_EV_EMIT;
                end
                S_EV_EMIT: begin
                    if (out_free) begin
                        m_joint_reg  <= ev_reg;
                        m_pos_reg    <= ev_res.position;
                        m_vel_reg    <= ev_res.velocity;
                        m_acc_reg    <= ev_res.acceleration;
                        m_dur_reg    <= longest_reg;
                        m_status_reg <= ev_res.sat ? qjt_pkg::ST_SAT : qjt_pkg::ST_OK;
                        m_last_reg   <= (ev_reg == 3'(EVAL_JOINTS - 1));
                        if (ev_reg == 3'(EVAL_JOINTS - 1)) begin
                            state_reg <= S_IDLE;
                        end else begin
                            ev_reg    <= ev_reg + 3'd1;
                            state_reg <= S_EV_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result packing
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'd0, m_status_reg, m_dur_reg, m_acc_reg, m_vel_reg, m_pos_reg,
                       m_joint_reg};

endmodule
